// ----- sv/lcls_pkg.sv -----
// ----------------------------------------------------------------------------
// lcls_pkg: shared definitions for the led cube layer scanner
// request kinds, stream payload widths and the layer select width
// ----------------------------------------------------------------------------
package lcls_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_SCAN  = 2'd2;

   // field widths
   localparam int MODE_W    = 2;
   localparam int COORD_W   = 3;
   localparam int ONEHOT_W  = 8;
   // coordinates widened so that a side of up to 16 compares cleanly
   localparam int COORD_EXT_W = 5;

   // packed stream payloads, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

endpackage

// ----- sv/led_cube_layer_scanner.sv -----
// ----------------------------------------------------------------------------
// led_cube_layer_scanner: voxel store and layer scan for a multiplexed cube
// keeps one bit per voxel and streams out one layer per scan tick, bit by bit
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                         | tuser / tlast
//  --------+-----------+--------------------------------------------+----------------------
//  req_    | in        | col_x[2:0] row_y[5:3] layer_z[8:6] lit[9]  | tuser = mode
//  rsp_    | out       | read_bit[0] layer_onehot[8:1] serial_bit[9]| tuser = is_read_reply,
//          |           |                                            | tlast = last
//
// a write goes into the ram in the cycle it is accepted; a read passes the ram
// read register on its way to the result register; a scan tick reads the current
// layer, one voxel per cycle while rsp_ is not stalled, and shifts it out serially.
// after reset a clearing pass writes zero to all 2**(3*clog2(CUBE_SIDE))
// ram entries (512 at side 8) one per cycle before req_tready rises.
// a stalled rsp_ holds the ram read register and pauses the scan in place.
//
module led_cube_layer_scanner
   import lcls_pkg::*;
#(
   parameter int CUBE_SIDE = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // col_x, row_y, layer_z, lit, zero pad
   input  logic [MODE_W-1:0]     req_tuser,   // mode
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // read_bit, layer_onehot, serial_bit, zero pad
   output logic                  rsp_tuser,   // is_read_reply
   output logic                  rsp_tlast
);

   localparam int CW    = $clog2(CUBE_SIDE);
   localparam int AW    = 3 * CW;
   localparam int DEPTH = 1 << AW;
   localparam logic [CW-1:0] SIDE_MAX = CW'(CUBE_SIDE - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN
   } state_type;

   // voxel ram, one bit per entry, address {layer, row, column}
   logic voxel_mem [DEPTH];

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [CW-1:0]        layer_ff, layer_in;
   logic [CW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic                 pend_ff, pend_in;
   logic                 pend_rd_ff, pend_rd_in;
   logic                 pend_ok_ff, pend_ok_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 ovalid_ff, ovalid_in;
   logic                 o_isrd_ff, o_isrd_in;
   logic                 o_rbit_ff, o_rbit_in;
   logic                 o_sbit_ff, o_sbit_in;
   logic                 o_last_ff, o_last_in;
   logic [ONEHOT_W-1:0]  o_onehot_ff, o_onehot_in;
   logic                 mem_q_ff;

   logic                 mem_we, mem_wd, mem_re;
   logic [AW-1:0]        mem_wa, mem_ra;
   logic                 accept, consume, issue, scan_end;
   logic [COORD_EXT_W-1:0] x_ext, y_ext, z_ext;
   logic                 coords_ok;
   logic [AW-1:0]        req_addr;
   logic                 req_lit;

   // request field unpacking
   assign x_ext    = COORD_EXT_W'(req_tdata[COORD_W-1:0]);
   assign y_ext    = COORD_EXT_W'(req_tdata[2*COORD_W-1:COORD_W]);
   assign z_ext    = COORD_EXT_W'(req_tdata[3*COORD_W-1:2*COORD_W]);
   assign req_lit  = req_tdata[3*COORD_W];
   assign coords_ok = (x_ext < COORD_EXT_W'(CUBE_SIDE)) &&
                      (y_ext < COORD_EXT_W'(CUBE_SIDE)) &&
                      (z_ext < COORD_EXT_W'(CUBE_SIDE));
   assign req_addr = {z_ext[CW-1:0], y_ext[CW-1:0], x_ext[CW-1:0]};

   // handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign consume    = pend_ff && (!ovalid_ff || rsp_tready);
   assign issue      = (state_ff == S_SCAN) && (!pend_ff || consume);
   assign scan_end   = (row_ff == SIDE_MAX) && (col_ff == SIDE_MAX);

   // next state, ram control and result register
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      layer_in     = layer_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pend_in      = pend_ff;
      pend_rd_in   = pend_rd_ff;
      pend_ok_in   = pend_ok_ff;
      pend_last_in = pend_last_ff;
      mem_we       = 1'b0;
      mem_wa       = req_addr;
      mem_wd       = req_lit;
      mem_re       = 1'b0;
      mem_ra       = {layer_ff, row_ff, col_ff};

      // pending ram data moves into the result register
      if (consume) begin
         pend_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = 1'b0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  MODE_WRITE: begin
                     mem_we = coords_ok;
                  end
                  MODE_READ: begin
                     mem_re       = 1'b1;
                     mem_ra       = req_addr;
                     pend_in      = 1'b1;
                     pend_rd_in   = 1'b1;
                     pend_ok_in   = coords_ok;
                     pend_last_in = 1'b0;
                     state_in     = S_DRAIN;
                  end
                  MODE_SCAN: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one voxel read per cycle while the result side keeps up
            if (issue) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_rd_in   = 1'b0;
               pend_ok_in   = 1'b1;
               pend_last_in = scan_end;
               if (col_ff == SIDE_MAX) begin
                  col_in = '0;
                  row_in = row_ff + CW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
               if (scan_end) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (consume) begin
               state_in = S_IDLE;
               // layer advances once its final bit moves into the result register
               if (pend_last_ff && !pend_rd_ff) begin
                  layer_in = (layer_ff == SIDE_MAX) ? '0 : layer_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register load
   always_comb begin
      ovalid_in   = ovalid_ff;
      o_isrd_in   = o_isrd_ff;
      o_rbit_in   = o_rbit_ff;
      o_sbit_in   = o_sbit_ff;
      o_last_in   = o_last_ff;
      o_onehot_in = o_onehot_ff;
      if (consume) begin
         ovalid_in   = 1'b1;
         o_isrd_in   = pend_rd_ff;
         o_rbit_in   = pend_rd_ff && pend_ok_ff && mem_q_ff;
         o_sbit_in   = !pend_rd_ff && mem_q_ff;
         o_last_in   = !pend_rd_ff && pend_last_ff;
         o_onehot_in = pend_rd_ff ? '0 : (ONEHOT_W'(1) << layer_ff);
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         layer_ff    <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         pend_ff     <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         layer_ff    <= layer_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         pend_ff     <= pend_in;
         ovalid_ff   <= ovalid_in;
      end
      pend_rd_ff   <= pend_rd_in;
      pend_ok_ff   <= pend_ok_in;
      pend_last_ff <= pend_last_in;
      o_isrd_ff    <= o_isrd_in;
      o_rbit_ff    <= o_rbit_in;
      o_sbit_ff    <= o_sbit_in;
      o_last_ff    <= o_last_in;
      o_onehot_ff  <= o_onehot_in;
   end

   // voxel ram: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= voxel_mem[mem_ra];
      end
   end

   // result stream
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = o_isrd_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_sbit_ff, o_onehot_ff, o_rbit_ff});

`ifndef SYNTHESIS
   // no read data may be in flight while new requests are taken
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("read data pending in idle");

   // a scan never disturbs the voxel ram contents
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_DRAIN) |-> !mem_we)
      else $error("voxel ram written during a scan");

   // ram read data holds while the result side is stalled
   a_hold_read_data: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !consume) |=> $stable(mem_q_ff))
      else $error("pending voxel lost under stall");

   // the layer only moves when the final bit of a layer transfers inward
   a_layer_step: assert property (@(posedge clock) disable iff (reset)
      !(consume && pend_last_ff && !pend_rd_ff) |=> $stable(layer_ff))
      else $error("layer counter moved outside a scan end");

   // a last marker belongs to a scan bit only
   a_last_is_scan: assert property (@(posedge clock) disable iff (reset)
      (consume && pend_rd_ff) |=> (!o_last_ff && o_onehot_ff == '0 && !o_sbit_ff))
      else $error("read answer carries scan fields");
`endif

endmodule
